>>> sv/assert_macros.svh
// Assertion macros for the RTL of the depthwise convolution block.
// Depends on nothing; included by causal_depthwise_conv_residual.sv, which carries the checks.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

>>> sv/cdcr_pkg.sv
// Package of the causal depthwise convolution block: beat types, codes and defaults.
// Depends on nothing; used by every module of the block but cdcr_ram.
package cdcr_pkg;

  localparam int CHANNELS_DEFAULT = 4096;
  localparam int MAX_TAPS_DEFAULT = 4;
  localparam int FIFO_DEPTH       = 4;

  localparam logic [2:0] TAPS_RESET = 3'd4;

  localparam logic FUNC_LOAD   = 1'b0;
  localparam logic FUNC_SAMPLE = 1'b1;

  typedef struct packed {
    logic               func;
    logic [11:0]        channel;
    logic [1:0]         tap;
    logic signed [15:0] value;
    logic               seq_start;
  } in_item_t;

  typedef struct packed {
    logic signed [15:0] result;
    logic [11:0]        out_channel;
    logic               saturated;
  } out_item_t;

  typedef struct packed {
    logic clear_busy;
    logic hist_item_we;
  } back_status_t;

endpackage

>>> sv/causal_depthwise_conv_residual.sv
// Causal depthwise 1-D convolution with residual. Weight-load beats (func 0) write one tap of
// one channel and give no result; sample beats (func 1) give one result each, the sample
// convolved with its channel's taps over its own history plus the sample itself, rounded to
// Q4.11 and saturated. The block takes one beat per cycle while in_stall is low. Without stalls,
// a sample passes the input register, the command queue, the back stages s1, s2 and s3 and
// the output register before out_valid rises. A stalled output register holds the whole back
// pipeline, and in_stall rises once the queue and the input register are both full.
// After reset the history store is cleared channel by channel, during which in_stall is high.
// Depends on cdcr_pkg, cdcr_front, cdcr_fifo, cdcr_back and assert_macros.svh.
`include "assert_macros.svh"

module causal_depthwise_conv_residual #(
  parameter int CHANNELS = cdcr_pkg::CHANNELS_DEFAULT,
  parameter int MAX_TAPS = cdcr_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  cdcr_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output cdcr_pkg::out_item_t out_data,
  input  logic                cfg_we,
  input  logic [2:0]          cfg_wdata
);

  logic [2:0] taps_r, taps_nxt;

  logic                   fifo_full;
  logic                   push;
  cdcr_pkg::in_item_t     push_item;
  logic                   front_busy;
  logic                   q_valid;
  cdcr_pkg::in_item_t     q_item;
  logic                   q_pop;
  cdcr_pkg::back_status_t status;

  assign taps_nxt = cfg_we ? cfg_wdata : taps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      taps_r <= cdcr_pkg::TAPS_RESET;
    end else begin
      taps_r <= taps_nxt;
    end
  end

  cdcr_front #(
    .CHANNELS(CHANNELS),
    .MAX_TAPS(MAX_TAPS)
  ) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .hold       (status.clear_busy),
    .fifo_full  (fifo_full),
    .push       (push),
    .push_item  (push_item),
    .front_busy (front_busy)
  );

  cdcr_fifo u_fifo (
    .clk        (clk),
    .rst_n      (rst_n),
    .push       (push),
    .push_item  (push_item),
    .full       (fifo_full),
    .pop        (q_pop),
    .head_valid (q_valid),
    .head_item  (q_item)
  );

  cdcr_back #(
    .CHANNELS(CHANNELS),
    .MAX_TAPS(MAX_TAPS)
  ) u_back (
    .clk         (clk),
    .rst_n       (rst_n),
    .taps_in_use (taps_r),
    .q_valid     (q_valid),
    .q_item      (q_item),
    .q_pop       (q_pop),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data),
    .status      (status)
  );

  `ASSERT_IMPLIES(a_no_take_while_clearing, clk, rst_n, status.clear_busy, in_stall)
  `ASSERT_IMPLIES(a_no_item_write_while_clearing, clk, rst_n, status.hist_item_we, !status.clear_busy)
  `ASSERT_NEXT(a_front_holds_taken_beat, clk, rst_n, in_valid && !in_stall, front_busy)

endmodule

>>> sv/cdcr_ram.sv
// Generic single-port-write, single-port-read RAM with registered, read-first output.
// Depends on nothing.
module cdcr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 4096
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic                                  re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> sv/cdcr_fifo.sv
// Short command queue between the front and back parts of the convolution block.
// Depends on cdcr_pkg.
module cdcr_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  cdcr_pkg::in_item_t push_item,
  output logic              full,
  input  logic              pop,
  output logic              head_valid,
  output cdcr_pkg::in_item_t head_item
);

  localparam int DEPTH = cdcr_pkg::FIFO_DEPTH;
  localparam int PW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW    = $clog2(DEPTH + 1);

  cdcr_pkg::in_item_t mem_r [DEPTH];
  logic [PW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;

  assign full       = (cnt_r == CW'(DEPTH));
  assign head_valid = (cnt_r != '0);
  assign head_item  = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == PW'(DEPTH - 1)) ? '0 : wr_ptr_r + PW'(1);
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == PW'(DEPTH - 1)) ? '0 : rd_ptr_r + PW'(1);
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + CW'(1);
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - CW'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_item;
    end
  end

endmodule

>>> sv/cdcr_front.sv
// Front part: takes input beats, drops out-of-range ones and feeds the command queue.
// Depends on cdcr_pkg.
module cdcr_front #(
  parameter int CHANNELS = cdcr_pkg::CHANNELS_DEFAULT,
  parameter int MAX_TAPS = cdcr_pkg::MAX_TAPS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  cdcr_pkg::in_item_t in_data,
  input  logic               hold,
  input  logic               fifo_full,
  output logic               push,
  output cdcr_pkg::in_item_t push_item,
  output logic               front_busy
);

  logic               occ_r, occ_nxt;
  logic               keep_r;
  cdcr_pkg::in_item_t cmd_r;
  logic               take;
  logic               drain;
  logic               keep_in;

  assign drain    = occ_r && (!keep_r || !fifo_full);
  assign in_stall = hold || (occ_r && !drain);
  assign take     = in_valid && !in_stall;
  assign push     = occ_r && keep_r && !fifo_full;
  assign push_item  = cmd_r;
  assign front_busy = occ_r;

  assign keep_in = (32'(in_data.channel) < 32'(CHANNELS)) &&
                   ((in_data.func == cdcr_pkg::FUNC_SAMPLE) ||
                    (32'(in_data.tap) < 32'(MAX_TAPS)));

  always_comb begin
    occ_nxt = occ_r;
    if (take) begin
      occ_nxt = 1'b1;
    end else if (drain) begin
      occ_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= 1'b0;
    end else begin
      occ_r <= occ_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      cmd_r  <= in_data;
      keep_r <= keep_in;
    end
  end

endmodule

>>> sv/cdcr_back.sv
// Back part: weight and history stores, tap multipliers, accumulation, rounding and output.
// Depends on cdcr_pkg and cdcr_ram.
module cdcr_back #(
  parameter int CHANNELS = cdcr_pkg::CHANNELS_DEFAULT,
  parameter int MAX_TAPS = cdcr_pkg::MAX_TAPS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic [2:0]             taps_in_use,
  input  logic                   q_valid,
  input  cdcr_pkg::in_item_t     q_item,
  output logic                   q_pop,
  output logic                   out_valid,
  input  logic                   out_stall,
  output cdcr_pkg::out_item_t    out_data,
  output cdcr_pkg::back_status_t status
);

  localparam int CH_AW  = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int HIST_N = (MAX_TAPS > 1) ? MAX_TAPS - 1 : 1;
  localparam int HIST_W = HIST_N * 16;
  localparam int TAP_AW = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int KW     = $clog2(MAX_TAPS + 1);
  localparam int ACC_W  = 33 + $clog2(MAX_TAPS + 1);
  localparam int QW     = ACC_W - 14;
  localparam logic signed [QW-1:0] QMAX = QW'(32767);
  localparam logic signed [QW-1:0] QMIN = QW'(-32768);

  logic [KW-1:0] k_eff;
  logic          adv;

  logic             clr_busy_r, clr_busy_nxt;
  logic [CH_AW-1:0] clr_addr_r, clr_addr_nxt;

  logic [31:0]      q_ch_ext;
  logic [CH_AW-1:0] q_addr;
  logic             rd_sample;

  logic               s1_valid_r;
  cdcr_pkg::in_item_t s1_cmd_r;
  logic [CH_AW-1:0]   s1_addr_r;

  logic [HIST_W-1:0]             hist_rdata;
  logic [HIST_N-1:0][15:0]       hist_cur;
  logic [HIST_N-1:0][15:0]       hist_new;
  logic                          hist_item_we;
  logic                          hist_we;
  logic [CH_AW-1:0]              hist_waddr;
  logic [HIST_W-1:0]             hist_wdata;

  logic             byp_valid_r;
  logic [CH_AW-1:0] byp_addr_r;
  logic [HIST_W-1:0] byp_data_r;

  logic signed [15:0] w_rd   [MAX_TAPS];
  logic signed [15:0] lane_s [MAX_TAPS];
  logic signed [15:0] lane_w [MAX_TAPS];
  logic signed [31:0] prod   [MAX_TAPS];

  logic               s2_valid_r;
  logic [11:0]        s2_ch_r;
  logic signed [31:0] s2_prod_r [MAX_TAPS];
  logic signed [15:0] s2_res_r;

  logic                   s3_valid_r;
  logic [11:0]            s3_ch_r;
  logic signed [ACC_W-1:0] s3_acc_r;
  logic signed [ACC_W-1:0] acc_sum;

  logic signed [ACC_W-1:0] acc_rnd;
  logic signed [QW-1:0]    q_val;
  logic signed [15:0]      res_sat;
  logic                    sat_flag;

  logic                out_valid_r;
  cdcr_pkg::out_item_t out_data_r;

  always_comb begin
    if (taps_in_use == 3'd0) begin
      k_eff = KW'(1);
    end else if (32'(taps_in_use) > 32'(MAX_TAPS)) begin
      k_eff = KW'(MAX_TAPS);
    end else begin
      k_eff = KW'(taps_in_use);
    end
  end

  assign adv = !out_valid_r || !out_stall;

  // History store clearing sweep after reset.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_addr_nxt = clr_addr_r;
    if (clr_busy_r) begin
      clr_addr_nxt = clr_addr_r + CH_AW'(1);
      if (clr_addr_r == CH_AW'(CHANNELS - 1)) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_addr_r <= '0;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  assign q_pop     = adv && q_valid && !clr_busy_r;
  assign q_ch_ext  = 32'(q_item.channel);
  assign q_addr    = q_ch_ext[CH_AW-1:0];
  assign rd_sample = q_pop && (q_item.func == cdcr_pkg::FUNC_SAMPLE);

  for (genvar j = 0; j < MAX_TAPS; j++) begin : g_wram
    logic [15:0] w_raw;
    cdcr_ram #(
      .WIDTH(16),
      .DEPTH(CHANNELS)
    ) u_wram (
      .clk   (clk),
      .we    (q_pop && (q_item.func == cdcr_pkg::FUNC_LOAD) &&
              (32'(q_item.tap) == j)),
      .waddr (q_addr),
      .wdata (q_item.value),
      .re    (rd_sample),
      .raddr (q_addr),
      .rdata (w_raw)
    );
    assign w_rd[j] = $signed(w_raw);
  end

  cdcr_ram #(
    .WIDTH(HIST_W),
    .DEPTH(CHANNELS)
  ) u_hram (
    .clk   (clk),
    .we    (hist_we),
    .waddr (hist_waddr),
    .wdata (hist_wdata),
    .re    (rd_sample),
    .raddr (q_addr),
    .rdata (hist_rdata)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (adv) begin
      s1_valid_r <= q_pop;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s1_cmd_r  <= q_item;
      s1_addr_r <= q_addr;
    end
  end

  // A read of a channel the beat just ahead wrote is stale; the bypass register covers it.
  always_comb begin
    if (s1_cmd_r.seq_start) begin
      hist_cur = '0;
    end else if (byp_valid_r && (byp_addr_r == s1_addr_r)) begin
      hist_cur = byp_data_r;
    end else begin
      hist_cur = hist_rdata;
    end
  end

  always_comb begin
    hist_new[0] = s1_cmd_r.value;
    for (int i = 1; i < HIST_N; i++) begin
      hist_new[i] = hist_cur[i-1];
    end
  end

  assign hist_item_we = adv && s1_valid_r && (s1_cmd_r.func == cdcr_pkg::FUNC_SAMPLE);
  assign hist_we      = clr_busy_r || hist_item_we;
  assign hist_waddr   = clr_busy_r ? clr_addr_r : s1_addr_r;
  assign hist_wdata   = clr_busy_r ? '0 : hist_new;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      byp_valid_r <= 1'b0;
    end else if (adv) begin
      byp_valid_r <= hist_item_we;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      byp_addr_r <= s1_addr_r;
      byp_data_r <= hist_new;
    end
  end

  for (genvar d = 0; d < MAX_TAPS; d++) begin : g_lane
    if (d == 0) begin : g_cur
      assign lane_s[d] = s1_cmd_r.value;
    end else begin : g_old
      assign lane_s[d] = $signed(hist_cur[d-1]);
    end

    always_comb begin
      lane_w[d] = '0;
      if (d < int'(k_eff)) begin
        lane_w[d] = w_rd[TAP_AW'(int'(k_eff) - 1 - d)];
      end
    end

    assign prod[d] = lane_s[d] * lane_w[d];

    always_ff @(posedge clk) begin
      if (adv) begin
        s2_prod_r[d] <= prod[d];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_valid_r <= 1'b0;
      s3_valid_r <= 1'b0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      s2_valid_r  <= s1_valid_r && (s1_cmd_r.func == cdcr_pkg::FUNC_SAMPLE);
      s3_valid_r  <= s2_valid_r;
      out_valid_r <= s3_valid_r;
    end
  end

  always_comb begin
    acc_sum = ACC_W'(s2_res_r) <<< 14;
    for (int d = 0; d < MAX_TAPS; d++) begin
      acc_sum = acc_sum + ACC_W'(s2_prod_r[d]);
    end
  end

  assign acc_rnd = s3_acc_r + ACC_W'(8192);
  assign q_val   = QW'(acc_rnd >>> 14);

  always_comb begin
    sat_flag = 1'b0;
    res_sat  = q_val[15:0];
    if (q_val > QMAX) begin
      res_sat  = 16'sh7fff;
      sat_flag = 1'b1;
    end else if (q_val < QMIN) begin
      res_sat  = 16'sh8000;
      sat_flag = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s2_ch_r  <= s1_cmd_r.channel;
      s2_res_r <= s1_cmd_r.value;
      s3_ch_r  <= s2_ch_r;
      s3_acc_r <= acc_sum;
      out_data_r.result      <= res_sat;
      out_data_r.out_channel <= s3_ch_r;
      out_data_r.saturated   <= sat_flag;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  assign status.clear_busy   = clr_busy_r;
  assign status.hist_item_we = hist_item_we;

endmodule
